FILE: rtl/gsb_pkg.sv
package gsb_pkg;

  localparam int VID_W    = 6;
  localparam int ACT_W    = 3;
  localparam int ID_SPACE = 2 ** VID_W;

  localparam logic [ACT_W-1:0] ACT_ADD_V = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DEL_V = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADD_E = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_E = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ADJ   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PRES  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_BIP   = 3'd6;

  // adjacency row read address source
  localparam logic [1:0] SRC_A   = 2'd0;
  localparam logic [1:0] SRC_B   = 2'd1;
  localparam logic [1:0] SRC_IDX = 2'd2;
  localparam logic [1:0] SRC_QV  = 2'd3;

  // adjacency row write kind
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_A     = 2'd1;
  localparam logic [1:0] WR_B     = 2'd2;
  localparam logic [1:0] WR_SWEEP = 2'd3;

  typedef struct packed {
    logic       take;
    logic       pres_set;
    logic       pres_clr;
    logic       row_rd;
    logic [1:0] row_src;
    logic [1:0] row_wr;
    logic       idx_clr;
    logic       idx_inc;
    logic       seed_clr;
    logic       seed_inc;
    logic       colour_clr;
    logic       seed_mark;
    logic       pop;
    logic       scan_mark;
    logic       out_load;
    logic       out_ans;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             a_ok;
    logic             b_ok;
    logic             pres_a;
    logic             pres_b;
    logic             a_eq_b;
    logic             row_bit_b;
    logic             row_bit_u;
    logic             col_u;
    logic             cold_u;
    logic             cv;
    logic             pres_s;
    logic             cold_s;
    logic             idx_last;
    logic             seed_last;
    logic             q_empty;
    logic             out_busy;
  } status_t;

endpackage

FILE: rtl/graph_store_bipartite_check_core.sv
// Undirected graph store with presence, edge and bipartite queries; one answer
// per transaction. Presence and colour bits live in flip-flops, adjacency rows
// in a one-write/one-read memory cleared at reset through per-row valid bits
// (no clearing pass). Vertex add/remove failures, add vertex and presence query
// are decided in the decode state; an adjacency query reads row a; add/remove
// edge read-modify-write both rows (a missing edge stops after reading row a);
// remove vertex is a read/write sweep that clears its column in every row and
// its own row; the bipartite check scans each row popped from the search queue
// one neighbor per cycle (V = min(VERTICES, 64) neighbors per row). A finished
// result sits in the output register while the next item is accepted; that
// item completes once the register is free.
module graph_store_bipartite_check_core #(
  parameter int VERTICES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [gsb_pkg::ACT_W-1:0] action,
  input  logic [gsb_pkg::VID_W-1:0] vertex_a,
  input  logic [gsb_pkg::VID_W-1:0] vertex_b,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic                      answer
);

  gsb_pkg::cmd_t    cmd;
  gsb_pkg::status_t st;

  gsb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .st         (st),
    .cmd        (cmd)
  );

  gsb_datapath #(
    .VERTICES (VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .action       (action),
    .vertex_a     (vertex_a),
    .vertex_b     (vertex_b),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .answer       (answer),
    .cmd          (cmd),
    .st           (st)
  );

endmodule

FILE: rtl/gsb_ctrl.sv
module gsb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  gsb_pkg::status_t st,
  output gsb_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_EDGE_A   = 4'd2;
  localparam logic [3:0] S_EDGE_B   = 4'd3;
  localparam logic [3:0] S_SWEEP_RD = 4'd4;
  localparam logic [3:0] S_SWEEP_WR = 4'd5;
  localparam logic [3:0] S_SEED     = 4'd6;
  localparam logic [3:0] S_POP      = 4'd7;
  localparam logic [3:0] S_POP_WAIT = 4'd8;
  localparam logic [3:0] S_SCAN     = 4'd9;
  localparam logic [3:0] S_FINISH   = 4'd10;

  logic [3:0] state, state_next;
  logic       held, held_next;
  logic       fin, fin_val;

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= 1'b0;
    end else begin
      state <= state_next;
      held  <= held_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    held_next  = held;
    fin        = 1'b0;
    fin_val    = 1'b0;

    case (state)
      S_IDLE: begin
        cmd.take = item_valid;
        if (item_valid) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        case (st.action)
          gsb_pkg::ACT_ADD_V: begin
            fin          = 1'b1;
            fin_val      = st.a_ok && !st.pres_a;
            cmd.pres_set = st.a_ok && !st.pres_a;
          end
          gsb_pkg::ACT_DEL_V: begin
            if (st.pres_a) begin
              cmd.pres_clr = 1'b1;
              cmd.idx_clr  = 1'b1;
              state_next   = S_SWEEP_RD;
            end else begin
              fin = 1'b1;
            end
          end
          gsb_pkg::ACT_ADD_E: begin
            if (st.pres_a && st.pres_b && !st.a_eq_b) begin
              cmd.row_rd  = 1'b1;
              cmd.row_src = gsb_pkg::SRC_A;
              state_next  = S_EDGE_A;
            end else begin
              fin = 1'b1;
            end
          end
          gsb_pkg::ACT_DEL_E: begin
            if (st.pres_a && st.pres_b) begin
              cmd.row_rd  = 1'b1;
              cmd.row_src = gsb_pkg::SRC_A;
              state_next  = S_EDGE_A;
            end else begin
              fin = 1'b1;
            end
          end
          gsb_pkg::ACT_ADJ: begin
            if (st.pres_a && st.b_ok) begin
              cmd.row_rd  = 1'b1;
              cmd.row_src = gsb_pkg::SRC_A;
              state_next  = S_EDGE_A;
            end else begin
              fin = 1'b1;
            end
          end
          gsb_pkg::ACT_PRES: begin
            fin     = 1'b1;
            fin_val = st.pres_a;
          end
          gsb_pkg::ACT_BIP: begin
            cmd.colour_clr = 1'b1;
            cmd.seed_clr   = 1'b1;
            state_next     = S_SEED;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_EDGE_A: begin
        if (st.action == gsb_pkg::ACT_ADJ) begin
          fin     = 1'b1;
          fin_val = st.row_bit_b;
        end else if (st.action == gsb_pkg::ACT_DEL_E && !st.row_bit_b) begin
          fin = 1'b1;
        end else begin
          cmd.row_wr  = gsb_pkg::WR_A;
          cmd.row_rd  = 1'b1;
          cmd.row_src = gsb_pkg::SRC_B;
          state_next  = S_EDGE_B;
        end
      end

      S_EDGE_B: begin
        cmd.row_wr = gsb_pkg::WR_B;
        fin        = 1'b1;
        fin_val    = 1'b1;
      end

      S_SWEEP_RD: begin
        cmd.row_rd  = 1'b1;
        cmd.row_src = gsb_pkg::SRC_IDX;
        state_next  = S_SWEEP_WR;
      end

      S_SWEEP_WR: begin
        cmd.row_wr = gsb_pkg::WR_SWEEP;
        if (st.idx_last) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SWEEP_RD;
        end
      end

      S_SEED: begin
        if (st.pres_s && !st.cold_s) begin
          cmd.seed_mark = 1'b1;
          state_next    = S_POP;
        end else if (st.seed_last) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd.seed_inc = 1'b1;
        end
      end

      S_POP: begin
        if (!st.q_empty) begin
          cmd.pop    = 1'b1;
          state_next = S_POP_WAIT;
        end else if (st.seed_last) begin
          fin     = 1'b1;
          fin_val = 1'b1;
        end else begin
          cmd.seed_inc = 1'b1;
          state_next   = S_SEED;
        end
      end

      S_POP_WAIT: begin
        cmd.row_rd  = 1'b1;
        cmd.row_src = gsb_pkg::SRC_QV;
        cmd.idx_clr = 1'b1;
        state_next  = S_SCAN;
      end

      S_SCAN: begin
        // neighbor already coloured with the same colour: odd cycle
        if (st.row_bit_u && st.cold_u && (st.col_u == st.cv)) begin
          fin = 1'b1;
        end else begin
          cmd.scan_mark = st.row_bit_u && !st.cold_u;
          if (st.idx_last) begin
            state_next = S_POP;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end

      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_ans  = held;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      if (!st.out_busy) begin
        cmd.out_load = 1'b1;
        cmd.out_ans  = fin_val;
        state_next   = S_IDLE;
      end else begin
        held_next  = fin_val;
        state_next = S_FINISH;
      end
    end
  end

endmodule

FILE: rtl/gsb_datapath.sv
module gsb_datapath #(
  parameter int VERTICES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [gsb_pkg::ACT_W-1:0]  action,
  input  logic [gsb_pkg::VID_W-1:0]  vertex_a,
  input  logic [gsb_pkg::VID_W-1:0]  vertex_b,
  input  logic                       result_ready,
  output logic                       result_valid,
  output logic                       answer,
  input  gsb_pkg::cmd_t              cmd,
  output gsb_pkg::status_t           st
);

  // ids are only VID_W bits wide, so no vertex beyond the id space can exist
  localparam int N  = (VERTICES < gsb_pkg::ID_SPACE) ? VERTICES : gsb_pkg::ID_SPACE;
  localparam int IW = $clog2(N);
  localparam logic [gsb_pkg::VID_W:0] NLIM = N[gsb_pkg::VID_W:0];

  logic [gsb_pkg::ACT_W-1:0] item_action;
  logic [gsb_pkg::VID_W-1:0] item_a, item_b;

  logic [N-1:0] present, colour, coloured;

  logic [N-1:0] adj_mem [N];
  logic [N-1:0] row_valid;
  logic [N-1:0] row_q;
  logic         row_ok_q;
  logic [N-1:0] row_eff;

  logic [IW-1:0] q_mem [N];
  logic [IW-1:0] q_q;

  logic [IW-1:0] idx, seed;
  logic [IW:0]   head, tail;

  logic [IW-1:0] a_i, b_i;
  logic          a_ok, b_ok, edge_set;
  logic [IW-1:0] rd_addr, wr_addr, q_waddr;
  logic [N-1:0]  wr_data;
  logic          q_we;

  assign a_i      = item_a[IW-1:0];
  assign b_i      = item_b[IW-1:0];
  assign a_ok     = ({1'b0, item_a} < NLIM);
  assign b_ok     = ({1'b0, item_b} < NLIM);
  assign edge_set = (item_action == gsb_pkg::ACT_ADD_E);
  assign row_eff  = row_ok_q ? row_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item_action <= action;
      item_a      <= vertex_a;
      item_b      <= vertex_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (cmd.pres_set) begin
      present[a_i] <= 1'b1;
    end else if (cmd.pres_clr) begin
      present[a_i] <= 1'b0;
    end
  end

  always_comb begin
    case (cmd.row_src)
      gsb_pkg::SRC_A:   rd_addr = a_i;
      gsb_pkg::SRC_B:   rd_addr = b_i;
      gsb_pkg::SRC_IDX: rd_addr = idx;
      default:          rd_addr = q_q;
    endcase
  end

  always_comb begin
    wr_data = row_eff;
    case (cmd.row_wr)
      gsb_pkg::WR_A: begin
        wr_addr          = a_i;
        wr_data[b_i]     = edge_set;
      end
      gsb_pkg::WR_B: begin
        wr_addr          = b_i;
        wr_data[a_i]     = edge_set;
      end
      gsb_pkg::WR_SWEEP: begin
        wr_addr          = idx;
        wr_data[a_i]     = 1'b0;
        if (idx == a_i) begin
          wr_data = '0;
        end
      end
      default: begin
        wr_addr = idx;
      end
    endcase
  end

  // adjacency rows: one write and one read per cycle, invalid rows read as zero
  always_ff @(posedge clk) begin
    if (cmd.row_wr != gsb_pkg::WR_NONE) begin
      adj_mem[wr_addr] <= wr_data;
    end
    if (cmd.row_rd) begin
      row_q    <= adj_mem[rd_addr];
      row_ok_q <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.row_wr != gsb_pkg::WR_NONE) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  assign q_we    = cmd.seed_mark || cmd.scan_mark;
  assign q_waddr = cmd.seed_mark ? '0 : tail[IW-1:0];

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= cmd.seed_mark ? seed : idx;
    end
    if (cmd.pop) begin
      q_q <= q_mem[head[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour   <= '0;
      coloured <= '0;
    end else if (cmd.colour_clr) begin
      colour   <= '0;
      coloured <= '0;
    end else if (cmd.seed_mark) begin
      colour[seed]   <= 1'b1;
      coloured[seed] <= 1'b1;
    end else if (cmd.scan_mark) begin
      colour[idx]   <= ~colour[q_q];
      coloured[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      seed <= '0;
      head <= '0;
      tail <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.seed_clr) begin
        seed <= '0;
      end else if (cmd.seed_inc) begin
        seed <= seed + IW'(1);
      end
      if (cmd.seed_mark) begin
        head <= '0;
        tail <= (IW+1)'(1);
      end else begin
        if (cmd.pop) begin
          head <= head + (IW+1)'(1);
        end
        if (cmd.scan_mark) begin
          tail <= tail + (IW+1)'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      answer <= cmd.out_ans;
    end
  end

  always_comb begin
    st.action    = item_action;
    st.a_ok      = a_ok;
    st.b_ok      = b_ok;
    st.pres_a    = a_ok && present[a_i];
    st.pres_b    = b_ok && present[b_i];
    st.a_eq_b    = (item_a == item_b);
    st.row_bit_b = row_eff[b_i];
    st.row_bit_u = row_eff[idx];
    st.col_u     = colour[idx];
    st.cold_u    = coloured[idx];
    st.cv        = colour[q_q];
    st.pres_s    = present[seed];
    st.cold_s    = coloured[seed];
    st.idx_last  = (idx == IW'(N - 1));
    st.seed_last = (seed == IW'(N - 1));
    st.q_empty   = (head == tail);
    st.out_busy  = result_valid && !result_ready;
  end

endmodule

FILE: rtl/gsb_check.sv
module gsb_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic [gsb_pkg::ACT_W-1:0] action,
  input logic [gsb_pkg::VID_W-1:0] vertex_a,
  input logic [gsb_pkg::VID_W-1:0] vertex_b,
  input logic                      result_valid,
  input logic                      result_ready,
  input logic                      answer
);

  // one transaction at a time: intake closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("intake stayed open after an accepted transaction");

  // a new result is only produced while an item is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared with no item in progress");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(answer))
    else $error("stalled result changed or dropped");

endmodule

bind graph_store_bipartite_check_core gsb_check u_gsb_check (.*);

FILE: bench/graph_store_bipartite_check_core_tb.sv
module graph_store_bipartite_check_core_tb;

  localparam int VERTICES = 64;
  localparam logic [gsb_pkg::ACT_W-1:0] ACT_NONE = 3'd7;
  localparam int RANDOM_OPS = 1150;

  typedef struct packed {
    logic [gsb_pkg::ACT_W-1:0] action;
    logic [gsb_pkg::VID_W-1:0] va;
    logic [gsb_pkg::VID_W-1:0] vb;
  } graph_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  logic [gsb_pkg::ACT_W-1:0] action = '0;
  logic [gsb_pkg::VID_W-1:0] vertex_a = '0;
  logic [gsb_pkg::VID_W-1:0] vertex_b = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic answer;

  graph_store_bipartite_check_core #(.VERTICES(VERTICES)) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .action(action),
    .vertex_a(vertex_a),
    .vertex_b(vertex_b),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .answer(answer)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the graph store
  logic [gsb_pkg::ID_SPACE-1:0] present_map;
  logic [gsb_pkg::ID_SPACE-1:0] adj_rows [gsb_pkg::ID_SPACE];
  logic [gsb_pkg::ID_SPACE-1:0] hue_map;
  logic [gsb_pkg::ID_SPACE-1:0] marked_map;

  graph_op_t   pending_ops [$];
  logic        answer_fifo [$];
  int          ops_total = 0;
  int          ops_accepted = 0;
  int          results_seen = 0;
  int          error_count = 0;
  longint      cycle_count = 0;
  longint      cycle_limit = 64'd100000000;

  logic        item_taken = 1'b0;
  logic        result_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          drv_quiet = 1'b0;
  bit          mon_quiet = 1'b0;

  logic [gsb_pkg::VID_W-1:0] pool [8];
  int                        pool_n = 4;

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : int'($urandom_range(0, 17));
  endfunction

  // BFS two-coloring, a fresh search from every uncolored present vertex
  function automatic logic graph_two_colourable();
    logic [gsb_pkg::VID_W-1:0] bfs_q [gsb_pkg::ID_SPACE];
    int head, tail, s, u;
    logic [gsb_pkg::VID_W-1:0] v;
    logic cv;
    hue_map = '0;
    marked_map = '0;
    for (s = 0; s < VERTICES; s++) begin
      if (!present_map[s] || marked_map[s]) continue;
      head = 0;
      tail = 0;
      marked_map[s] = 1'b1;
      hue_map[s] = 1'b1;
      bfs_q[tail] = s[gsb_pkg::VID_W-1:0];
      tail++;
      while (head < tail) begin
        v = bfs_q[head];
        head++;
        cv = hue_map[v];
        for (u = 0; u < VERTICES; u++) begin
          if (!adj_rows[v][u]) continue;
          if (marked_map[u]) begin
            if (hue_map[u] == cv) return 1'b0;
            continue;
          end
          marked_map[u] = 1'b1;
          hue_map[u] = !cv;
          if (tail < VERTICES) begin
            bfs_q[tail] = u[gsb_pkg::VID_W-1:0];
            tail++;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic logic graph_apply(input graph_op_t op);
    logic a_ok, b_ok, ans;
    int v;
    a_ok = op.va < VERTICES;
    b_ok = op.vb < VERTICES;
    ans = 1'b0;
    case (op.action)
      gsb_pkg::ACT_ADD_V: begin
        if (a_ok && !present_map[op.va]) begin
          present_map[op.va] = 1'b1;
          ans = 1'b1;
        end
      end
      gsb_pkg::ACT_DEL_V: begin
        if (a_ok && present_map[op.va]) begin
          for (v = 0; v < gsb_pkg::ID_SPACE; v++) adj_rows[v][op.va] = 1'b0;
          adj_rows[op.va] = '0;
          present_map[op.va] = 1'b0;
          ans = 1'b1;
        end
      end
      gsb_pkg::ACT_ADD_E: begin
        if (a_ok && b_ok && op.va != op.vb && present_map[op.va] &&
            present_map[op.vb]) begin
          adj_rows[op.va][op.vb] = 1'b1;
          adj_rows[op.vb][op.va] = 1'b1;
          ans = 1'b1;
        end
      end
      gsb_pkg::ACT_DEL_E: begin
        if (a_ok && b_ok && present_map[op.va] && present_map[op.vb] &&
            adj_rows[op.va][op.vb]) begin
          adj_rows[op.va][op.vb] = 1'b0;
          adj_rows[op.vb][op.va] = 1'b0;
          ans = 1'b1;
        end
      end
      gsb_pkg::ACT_ADJ:  if (a_ok && b_ok && present_map[op.va]) ans = adj_rows[op.va][op.vb];
      gsb_pkg::ACT_PRES: if (a_ok) ans = present_map[op.va];
      gsb_pkg::ACT_BIP:  ans = graph_two_colourable();
      default:           ans = 1'b0;
    endcase
    return ans;
  endfunction

  function automatic void queue_op(input logic [gsb_pkg::ACT_W-1:0] act,
                                   input logic [gsb_pkg::VID_W-1:0] a,
                                   input logic [gsb_pkg::VID_W-1:0] b);
    graph_op_t op;
    op.action = act;
    op.va = a;
    op.vb = b;
    pending_ops = {pending_ops, op};
  endfunction

  // side 0/1 selects the even or odd pool slots, so edges across sides tend to keep the graph bipartite
  function automatic logic [gsb_pkg::VID_W-1:0] pick_vertex(input int side);
    int cnt;
    if ($urandom_range(0, 99) < 20)
      return gsb_pkg::VID_W'($urandom_range(0, gsb_pkg::ID_SPACE - 1));
    cnt = (pool_n - side + 1) / 2;
    return pool[side + 2 * $urandom_range(0, cnt - 1)];
  endfunction

  // input side: prediction at acceptance
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      graph_op_t op;
      logic pred;
      op.action = action;
      op.va = vertex_a;
      op.vb = vertex_b;
      pred = graph_apply(op);
      answer_fifo = {answer_fifo, pred};
      ops_accepted++;
    end
    item_taken <= !rst && item_valid && item_ready;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && item_taken) gap_left = draw_wait(drv_quiet);
      if (!item_valid || item_taken) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          graph_op_t op;
          op = pending_ops[0];
          pending_ops.delete(0);
          action <= op.action;
          vertex_a <= op.va;
          vertex_b <= op.vb;
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      logic exp_ans;
      results_seen++;
      if (answer_fifo.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        exp_ans = answer_fifo[0];
        answer_fifo.delete(0);
        if (answer !== exp_ans)
          report_mismatch($sformatf("result %0d: answer %b, expected %b",
                                    results_seen, answer, exp_ans));
      end
    end
    result_taken <= !rst && result_valid && result_ready;
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) stall_left = draw_wait(mon_quiet);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int v, r, n_real, n_bip, side;
    present_map = '0;
    hue_map = '0;
    marked_map = '0;
    for (v = 0; v < gsb_pkg::ID_SPACE; v++) adj_rows[v] = '0;

    // directed part
    queue_op(gsb_pkg::ACT_BIP, 6'd0, 6'd0);     // empty graph
    queue_op(gsb_pkg::ACT_PRES, 6'd0, 6'd0);
    queue_op(gsb_pkg::ACT_ADD_V, 6'd0, 6'd63);
    queue_op(gsb_pkg::ACT_ADD_V, 6'd0, 6'd0);   // already present
    queue_op(gsb_pkg::ACT_ADD_V, 6'd63, 6'd0);
    queue_op(gsb_pkg::ACT_DEL_V, 6'd5, 6'd0);   // absent
    queue_op(gsb_pkg::ACT_ADD_E, 6'd0, 6'd0);   // self-loop
    queue_op(gsb_pkg::ACT_ADD_E, 6'd0, 6'd5);   // endpoint absent
    queue_op(gsb_pkg::ACT_ADD_E, 6'd0, 6'd63);
    queue_op(gsb_pkg::ACT_ADD_E, 6'd63, 6'd0);  // existing edge
    queue_op(gsb_pkg::ACT_ADJ, 6'd63, 6'd0);
    queue_op(gsb_pkg::ACT_ADJ, 6'd5, 6'd0);     // absent vertex
    queue_op(gsb_pkg::ACT_DEL_E, 6'd0, 6'd0);
    queue_op(gsb_pkg::ACT_ADD_V, 6'd42, 6'd21);
    queue_op(gsb_pkg::ACT_ADD_V, 6'd21, 6'd42);
    queue_op(gsb_pkg::ACT_ADD_E, 6'd63, 6'd42);
    queue_op(gsb_pkg::ACT_ADD_E, 6'd42, 6'd0);  // odd cycle
    queue_op(gsb_pkg::ACT_BIP, 6'd63, 6'd63);
    queue_op(gsb_pkg::ACT_DEL_E, 6'd42, 6'd0);
    queue_op(gsb_pkg::ACT_DEL_E, 6'd42, 6'd0);  // no longer there
    queue_op(gsb_pkg::ACT_BIP, 6'd0, 6'd0);
    queue_op(ACT_NONE, 6'd63, 6'd63);
    queue_op(gsb_pkg::ACT_DEL_V, 6'd63, 6'd0);  // takes its edges along
    queue_op(gsb_pkg::ACT_ADJ, 6'd0, 6'd63);
    queue_op(gsb_pkg::ACT_PRES, 6'd63, 6'd21);

    // random part: a small working pool keeps the graph connected enough to matter
    n_real = 0;
    while (n_real < RANDOM_OPS) begin
      if (n_real % 100 == 0) begin
        if (n_real > 0 && $urandom_range(0, 1) == 1)
          for (v = 0; v < pool_n; v++)
            queue_op(gsb_pkg::ACT_DEL_V, pool[v], gsb_pkg::VID_W'($urandom));
        pool_n = $urandom_range(4, 8);
        for (v = 0; v < pool_n; v++) begin
          pool[v] = gsb_pkg::VID_W'($urandom_range(0, gsb_pkg::ID_SPACE - 1));
          if ($urandom_range(0, 9) < 7)
            queue_op(gsb_pkg::ACT_ADD_V, pool[v], gsb_pkg::VID_W'($urandom));
        end
      end
      r = $urandom_range(0, 99);
      side = $urandom_range(0, 1);
      if (r < 18) queue_op(gsb_pkg::ACT_ADD_V, pick_vertex(side), gsb_pkg::VID_W'($urandom));
      else if (r < 25)
        queue_op(gsb_pkg::ACT_DEL_V, pick_vertex(side), gsb_pkg::VID_W'($urandom));
      else if (r < 55) begin
        if ($urandom_range(0, 99) < 85)
          queue_op(gsb_pkg::ACT_ADD_E, pick_vertex(side), pick_vertex(1 - side));
        else queue_op(gsb_pkg::ACT_ADD_E, pick_vertex(side), pick_vertex(side));
      end
      else if (r < 66)
        queue_op(gsb_pkg::ACT_DEL_E, pick_vertex(side), pick_vertex(1 - side));
      else if (r < 78)
        queue_op(gsb_pkg::ACT_ADJ, pick_vertex(side), pick_vertex($urandom_range(0, 1)));
      else if (r < 89)
        queue_op(gsb_pkg::ACT_PRES, pick_vertex(side), gsb_pkg::VID_W'($urandom));
      else if (r < 96)
        queue_op(gsb_pkg::ACT_BIP, gsb_pkg::VID_W'($urandom), gsb_pkg::VID_W'($urandom));
      else queue_op(ACT_NONE, gsb_pkg::VID_W'($urandom), gsb_pkg::VID_W'($urandom));
      if (r < 96) n_real++;
    end

    ops_total = pending_ops.size();
    n_bip = 0;
    foreach (pending_ops[i]) if (pending_ops[i].action == gsb_pkg::ACT_BIP) n_bip++;
    cycle_limit = 4 * (longint'(ops_total) * (40 + 2 * VERTICES + 10) +
                       longint'(n_bip) * (VERTICES * (VERTICES + 4) + 8)) + 20000;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (ops_accepted < ops_total || answer_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (answer_fifo.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", answer_fifo.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
